// ===== design/ptt_pkg.sv =====
// Package for the path tag table: operation codes, controller states and the
// structs that travel between the controller and the row of table cells.
// Depends on nothing; every other design file uses it by scoped names.
package ptt_pkg;

    // Operation codes of an input transaction.
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic [31:0] key;
        logic [7:0]  outn;
        logic [31:0] tag;
        logic        flush;
        logic        commit;
        logic        insert;
    } cmd_t;

    // Search token handed from one cell to the next.
    typedef struct packed {
        logic        tok;
        logic        hit_seen;
        logic        free_seen;
        logic        changed;
        logic        del;
        logic [31:0] old_tag;
    } link_t;

endpackage

// ===== design/ptt_cell.sv =====
// One table entry with its share of the search chain.
// Depends on ptt_pkg for cmd_t and link_t.
module ptt_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  ptt_pkg::cmd_t  cmd,
    input  ptt_pkg::link_t link_in,
    output ptt_pkg::link_t link_out
);

    logic        valid_reg;
    logic        valid_next;
    logic        cand_reg;
    logic        cand_next;
    logic [31:0] key_reg;
    logic [7:0]  outn_reg;
    logic [31:0] tag_reg;
    logic        hit;
    logic        take_hit;
    logic        take_free;
    logic        tag_diff;
    logic        write_tag;
    logic        write_all;
    ptt_pkg::link_t link_reg;
    ptt_pkg::link_t link_next;

    // Match and free-slot tests while the token sits at this cell.
    always_comb
    begin
        hit       = valid_reg && (key_reg == cmd.key) && (outn_reg == cmd.outn);
        take_hit  = link_in.tok && hit && !link_in.hit_seen;
        take_free = link_in.tok && !valid_reg && !link_in.free_seen && !link_in.hit_seen;
        tag_diff  = (tag_reg != cmd.tag);
        write_tag = take_hit && tag_diff;
        write_all = cmd.commit && cmd.insert && cand_reg;
    end

    // Token and running result handed on to the next cell.
    always_comb
    begin
        link_next           = link_in;
        link_next.hit_seen  = link_in.hit_seen || (link_in.tok && hit);
        link_next.free_seen = link_in.free_seen || take_free;
        link_next.changed   = link_in.changed || write_tag;
        if (write_tag && (tag_reg != 32'd0))
        begin
            link_next.del     = 1'b1;
            link_next.old_tag = tag_reg;
        end
    end

    // Valid mark and insert candidate.
    always_comb
    begin
        valid_next = valid_reg;
        cand_next  = cand_reg;
        if (cmd.flush)
        begin
            valid_next = 1'b0;
            cand_next  = 1'b0;
        end
        else if (cmd.commit)
        begin
            if (write_all)
            begin
                valid_next = 1'b1;
            end
            cand_next = 1'b0;
        end
        else if (take_free)
        begin
            cand_next = 1'b1;
        end
    end

    // Control state of the cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cand_reg  <= 1'b0;
            link_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cand_reg  <= cand_next;
            link_reg  <= link_next;
        end
    end

    // Entry contents; no reset needed.
    always_ff @(posedge clk)
    begin
        if (write_all)
        begin
            key_reg  <= cmd.key;
            outn_reg <= cmd.outn;
        end
        if (write_all || write_tag)
        begin
            tag_reg <= cmd.tag;
        end
    end

    assign link_out = link_reg;

endmodule

// ===== design/ptt_ctrl.sv =====
// Controller: takes transactions, launches the search token, commits an insert
// and registers the result. Depends on ptt_pkg.
module ptt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           operation,
    input  logic [31:0]    path_key,
    input  logic [7:0]     output_number,
    input  logic [31:0]    new_tag,
    input  ptt_pkg::link_t tail,
    output logic           busy,
    output ptt_pkg::cmd_t  cmd,
    output ptt_pkg::link_t head,
    output logic           done,
    output logic           tag_stored,
    output logic           delete_request,
    output logic [31:0]    old_tag,
    output logic           table_full
);

    ptt_pkg::state_t state_reg;
    ptt_pkg::state_t state_next;
    logic        tok0_reg;
    logic        accept;
    logic        commit;
    logic        flush;
    logic [31:0] key_reg;
    logic [7:0]  outn_reg;
    logic [31:0] tag_reg;
    logic        done_reg;
    logic        done_next;
    logic        changed_reg;
    logic        changed_next;
    logic        del_reg;
    logic        del_next;
    logic [31:0] old_reg;
    logic [31:0] old_next;
    logic        full_reg;
    logic        full_next;
    logic        insert;

    assign busy   = (state_reg != ptt_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign insert = !tail.hit_seen && tail.free_seen;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (operation == ptt_pkg::OP_FLUSH) ?
                                 ptt_pkg::ST_FLUSH : ptt_pkg::ST_SCAN;
                end
            end
            ptt_pkg::ST_SCAN:
            begin
                if (tail.tok)
                begin
                    state_next = ptt_pkg::ST_IDLE;
                end
            end
            ptt_pkg::ST_FLUSH:
            begin
                state_next = ptt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ptt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine and the next result.
    always_comb
    begin
        commit       = 1'b0;
        flush        = 1'b0;
        done_next    = 1'b0;
        changed_next = 1'b0;
        del_next     = 1'b0;
        old_next     = 32'd0;
        full_next    = 1'b0;
        case (state_reg)
            ptt_pkg::ST_SCAN:
            begin
                if (tail.tok)
                begin
                    commit    = 1'b1;
                    done_next = 1'b1;
                    if (tail.hit_seen)
                    begin
                        changed_next = tail.changed;
                        del_next     = tail.del;
                        old_next     = tail.del ? tail.old_tag : 32'd0;
                    end
                    else if (tail.free_seen)
                    begin
                        changed_next = 1'b1;
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                end
            end
            ptt_pkg::ST_FLUSH:
            begin
                flush     = 1'b1;
                done_next = 1'b1;
            end
            default:
            begin
                commit = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptt_pkg::ST_IDLE;
            tok0_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tok0_reg  <= accept && (operation == ptt_pkg::OP_UPDATE);
            done_reg  <= done_next;
        end
    end

    // Transaction payload and result registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg  <= path_key;
            outn_reg <= output_number;
            tag_reg  <= new_tag;
        end
        changed_reg <= changed_next;
        del_reg     <= del_next;
        old_reg     <= old_next;
        full_reg    <= full_next;
    end

    // Broadcast to the cells and the head of the chain.
    always_comb
    begin
        cmd.key      = key_reg;
        cmd.outn     = outn_reg;
        cmd.tag      = tag_reg;
        cmd.flush    = flush;
        cmd.commit   = commit;
        cmd.insert   = insert;
        head         = '0;
        head.tok     = tok0_reg;
    end

    assign done           = done_reg;
    assign tag_stored     = changed_reg;
    assign delete_request = del_reg;
    assign old_tag        = old_reg;
    assign table_full     = full_reg;

endmodule

// ===== design/path_tag_table.sv =====
// Top level of the path tag table: controller and a row of TABLE_DEPTH cells.
// Depends on ptt_pkg, ptt_cell and ptt_ctrl.
//
//  Channel | Ports                                             | Handshake
//  --------+---------------------------------------------------+-----------------------
//  request | operation, path_key, output_number, new_tag       | start high, busy low
//  result  | tag_stored, delete_request, old_tag, table_full   | done high for one cycle
//
// An update sends a token down the cell row, one cell per clock, so the row
// length sets the time from acceptance to done. busy is low again in the
// cycle that done is shown.
// Reset clears all valid marks at once; no clearing pass is needed.
// The receiver cannot stall: each result is taken in the cycle it is shown.
module path_tag_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [31:0] path_key,
    input  logic [7:0]  output_number,
    input  logic [31:0] new_tag,
    output logic        done,
    output logic        tag_stored,
    output logic        delete_request,
    output logic [31:0] old_tag,
    output logic        table_full
);

    ptt_pkg::cmd_t  cmd;
    ptt_pkg::link_t chain [TABLE_DEPTH + 1];

    // Controller.
    ptt_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .operation      (operation),
        .path_key       (path_key),
        .output_number  (output_number),
        .new_tag        (new_tag),
        .tail           (chain[TABLE_DEPTH]),
        .busy           (busy),
        .cmd            (cmd),
        .head           (chain[0]),
        .done           (done),
        .tag_stored     (tag_stored),
        .delete_request (delete_request),
        .old_tag        (old_tag),
        .table_full     (table_full)
    );

    // Row of table cells.
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        ptt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .link_in  (chain[i]),
            .link_out (chain[i + 1])
        );
    end

    // A delete request always comes with a change and a nonzero old tag.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && delete_request |-> tag_stored && (old_tag != 32'd0))
        else $error("delete request without change or with zero old tag");

    // A full table never reports a change.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && table_full |-> !tag_stored && !delete_request)
        else $error("table full reported together with a change");

    // An accepted transaction makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // A result appears only as the block leaves its busy period.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe outside the end of a transaction");

    // Tokens only enter the cell row right after an accepted update.
    assert property (@(posedge clk) disable iff (!rst_n)
        chain[0].tok |-> $past(start && !busy && (operation == ptt_pkg::OP_UPDATE)))
        else $error("search token launched without an accepted update");

endmodule
